// ===== sv/dpts_pkg.sv =====
// ----------------------------------------------------------------------------
// Scheduler package
// Shared constants, status codes, cell commands and types.
// ----------------------------------------------------------------------------
package dpts_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int WAKE_BITS     = 16;
    localparam logic [7:0] LOAD_CEILING_RESET = 8'd128;
    localparam logic [3:0] IDLE_RESET         = 4'd1;

    localparam logic [2:0] ST_UNUSED   = 3'd0;
    localparam logic [2:0] ST_RUN      = 3'd1;
    localparam logic [2:0] ST_BLK      = 3'd2;
    localparam logic [2:0] ST_SPECIAL  = 3'd3;
    localparam logic [2:0] ST_DBG_STOP = 3'd4;
    localparam logic [2:0] ST_DBG_BLK  = 3'd5;
    localparam logic [2:0] ST_HELD_RUN = 3'd6;
    localparam logic [2:0] ST_HELD_BLK = 3'd7;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_GROUP = 2'd2;

    localparam logic [1:0] GOP_STOP   = 2'd0;
    localparam logic [1:0] GOP_RESUME = 2'd1;
    localparam logic [1:0] GOP_HOLD   = 2'd2;

    localparam logic [1:0] CFG_MAX_LOAD = 2'd0;
    localparam logic [1:0] CFG_IDLE     = 2'd1;

    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_WRITE    = 3'd1;
    localparam logic [2:0] CMD_GROUP    = 3'd2;
    localparam logic [2:0] CMD_AGE_WAKE = 3'd3;
    localparam logic [2:0] CMD_SUB      = 3'd4;
    localparam logic [2:0] CMD_CHARGE   = 3'd5;
    localparam logic [2:0] CMD_LOADINC  = 3'd6;
    localparam logic [2:0] CMD_DPSET    = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] status;
        logic [7:0] prio;
        logic [7:0] pid;
        logic [1:0] gop;
        logic [8:0] lowest;
        logic [7:0] max_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] proc_id;
        logic [7:0] sprio;
        logic [8:0] dprio;
        logic [7:0] load;
        logic       inr;
    } t_entry;

endpackage

// ===== sv/dpts_cell.sv =====
// ----------------------------------------------------------------------------
// Scheduler thread cell
// Holds one thread entry and applies the broadcast command to it.
// ----------------------------------------------------------------------------
module dpts_cell
    import dpts_pkg::*;
#(
    parameter int IDX_W = 4,
    parameter int INDEX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [IDX_W-1:0] i_sel,
    input  logic [IDX_W-1:0] i_run,
    input  logic             i_wake,
    output t_entry           o_entry
);

    t_entry r_e, n_e;
    logic   hit;
    logic [8:0] diff;

    assign hit  = (i_sel == IDX_W'(INDEX));
    assign diff = r_e.dprio - i_cmd.lowest;

    always_comb begin
        n_e = r_e;
        unique case (i_cmd.op)
            CMD_NONE: begin
            end
            CMD_WRITE: begin
                if (hit) begin
                    n_e.status  = i_cmd.status;
                    n_e.proc_id = i_cmd.pid;
                    n_e.sprio   = i_cmd.prio;
                    n_e.dprio   = {1'b0, i_cmd.prio};
                    n_e.load    = 8'd0;
                    n_e.inr     = 1'b0;
                end
            end
            CMD_GROUP: begin
                if (r_e.proc_id == i_cmd.pid) begin
                    case (i_cmd.gop)
                        GOP_STOP: begin
                            if (r_e.status == ST_RUN) n_e.status = ST_DBG_STOP;
                            else if (r_e.status == ST_BLK) n_e.status = ST_DBG_BLK;
                        end
                        GOP_RESUME: begin
                            if (r_e.status == ST_DBG_STOP) n_e.status = ST_RUN;
                            else if (r_e.status == ST_DBG_BLK) n_e.status = ST_BLK;
                        end
                        GOP_HOLD: begin
                            if (i_run != IDX_W'(INDEX)) begin
                                if (r_e.status == ST_RUN) n_e.status = ST_HELD_RUN;
                                else if (r_e.status == ST_BLK) n_e.status = ST_HELD_BLK;
                            end
                        end
                        default: begin
                            if (r_e.status == ST_HELD_RUN) n_e.status = ST_RUN;
                            else if (r_e.status == ST_HELD_BLK) n_e.status = ST_BLK;
                        end
                    endcase
                end
            end
            CMD_AGE_WAKE: begin
                if (r_e.load != 8'd0) n_e.load = r_e.load - 8'd1;
                if (r_e.status == ST_BLK && i_wake) n_e.status = ST_RUN;
            end
            CMD_SUB: begin
                n_e.inr = 1'b0;
                if (r_e.status == ST_RUN) begin
                    n_e.dprio = diff;
                    n_e.inr   = (diff == 9'd0);
                end
            end
            CMD_CHARGE: begin
                if (hit && r_e.load != 8'hFF) n_e.load = r_e.load + 8'd1;
            end
            CMD_LOADINC: begin
                if (hit && r_e.load < i_cmd.max_load) n_e.load = r_e.load + 8'd1;
            end
            CMD_DPSET: begin
                if (hit) n_e.dprio = {1'b0, r_e.sprio} + {1'b0, r_e.load};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e <= '0;
        end else begin
            r_e <= n_e;
        end
    end

    assign o_entry = r_e;

endmodule

// ===== sv/dynamic_priority_thread_scheduler.sv =====
// ----------------------------------------------------------------------------
// Dynamic priority thread scheduler
// A row of thread cells driven by a serial sequencer that scans the row.
// ----------------------------------------------------------------------------
// Items arrive on the s_axis channel, one per transfer; every item gives one
// result transfer on m_axis. Mode 0 is a schedule tick, mode 1 writes one
// entry, mode 2 applies a debug or hold operation to the entries of a pid.
// A tick first scans the entries after the running one for the next round
// member; if none is found it plans a round, walking the row once for the
// lowest dynamic priority and once to pick the next thread, one entry per
// cycle. The walks go over the cell row through a single read port.
// The cfg channel writes max_load (index 0) and idle_index (index 1) and is
// always ready. Reset clears every entry, the running index and the round
// count, and loads max_load 128 and idle_index 1. The output register holds a
// result while the receiver stalls; a new item is taken meanwhile, and its
// result waits until the held one is transferred.
// ----------------------------------------------------------------------------
module dynamic_priority_thread_scheduler
    import dpts_pkg::*;
#(
    parameter int THREAD_SLOTS = SLOTS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode[1:0], wake_mask[17:2], entry_index[21:18], new_status[24:22],
    // base_priority[32:25], proc_id[40:33], group_op[42:41], zero fill
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // running_thread[3:0], is_idle[4], rejected[5], round_number[37:6], fill
    output logic [39:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int IDX_W = $clog2(THREAD_SLOTS);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(THREAD_SLOTS - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_AGE    = 4'd3;
    localparam logic [3:0] S_MIN    = 4'd4;
    localparam logic [3:0] S_SUB    = 4'd5;
    localparam logic [3:0] S_CHARGE = 4'd6;
    localparam logic [3:0] S_INC    = 4'd7;
    localparam logic [3:0] S_DPSET  = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0]       r_state;
    logic [47:0]      r_in;
    logic [IDX_W-1:0] r_j, r_run, r_nxt;
    logic             r_found, r_rej;
    logic [8:0]       r_low;
    logic [31:0]      r_round;
    logic [7:0]       r_max_load;
    logic [3:0]       r_idle;
    logic             r_ovalid;
    logic [39:0]      r_odata;

    t_entry           entries [THREAD_SLOTS];
    t_entry           cur;
    t_cmd             cmd;
    logic [IDX_W-1:0] sel, idle_eff, wr_idx;
    logic [31:0]      idle32, wr32, run32;
    logic             wr_ok, rej_now;

    logic [1:0]  in_mode;
    logic [15:0] in_wake;
    logic [3:0]  in_idx;
    logic [2:0]  in_status;
    logic [7:0]  in_prio, in_pid;
    logic [1:0]  in_gop;

    assign in_mode   = r_in[1:0];
    assign in_wake   = r_in[17:2];
    assign in_idx    = r_in[21:18];
    assign in_status = r_in[24:22];
    assign in_prio   = r_in[32:25];
    assign in_pid    = r_in[40:33];
    assign in_gop    = r_in[42:41];

    assign cur      = entries[r_j];
    assign idle32   = 32'(r_idle);
    assign idle_eff = (idle32 < 32'(THREAD_SLOTS)) ? idle32[IDX_W-1:0] : '0;
    assign wr32     = 32'(in_idx);
    assign wr_idx   = wr32[IDX_W-1:0];
    assign wr_ok    = wr32 < 32'(THREAD_SLOTS);
    assign run32    = 32'(r_run);
    assign rej_now  = (in_gop == GOP_STOP) && (entries[r_run].proc_id == in_pid);

    generate
        for (genvar g = 0; g < THREAD_SLOTS; g++) begin : g_cell
            logic wake_bit;
            if (g < WAKE_BITS) begin : g_wake
                assign wake_bit = in_wake[g];
            end else begin : g_nowake
                assign wake_bit = 1'b0;
            end
            dpts_cell #(.IDX_W(IDX_W), .INDEX(g)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (cmd),
                .i_sel   (sel),
                .i_run   (r_run),
                .i_wake  (wake_bit),
                .o_entry (entries[g])
            );
        end
    endgenerate

    always_comb begin
        cmd          = '0;
        cmd.op       = CMD_NONE;
        cmd.status   = in_status;
        cmd.prio     = in_prio;
        cmd.pid      = in_pid;
        cmd.gop      = in_gop;
        cmd.lowest   = r_low;
        cmd.max_load = r_max_load;
        sel          = r_nxt;
        unique case (r_state)
            S_DISP: begin
                sel = wr_idx;
                if (in_mode == MODE_WRITE && wr_ok) cmd.op = CMD_WRITE;
                else if (in_mode == MODE_GROUP && !rej_now) cmd.op = CMD_GROUP;
            end
            S_AGE:    cmd.op = CMD_AGE_WAKE;
            S_SUB:    cmd.op = CMD_SUB;
            S_CHARGE: begin
                sel = r_run;
                if (cur.inr) cmd.op = CMD_CHARGE;
            end
            S_INC:    cmd.op = CMD_LOADINC;
            S_DPSET:  cmd.op = CMD_DPSET;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_run      <= '0;
            r_round    <= '0;
            r_max_load <= LOAD_CEILING_RESET;
            r_idle     <= IDLE_RESET;
            r_ovalid   <= 1'b0;
            r_j        <= '0;
            r_nxt      <= '0;
            r_found    <= 1'b0;
            r_rej      <= 1'b0;
            r_low      <= '1;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_MAX_LOAD) r_max_load <= i_cfg_data;
                else if (i_cfg_index == CFG_IDLE) r_idle <= i_cfg_data[3:0];
            end
            if (r_ovalid && m_axis_tready && r_state != S_OUT) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_in    <= s_axis_tdata;
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_rej <= (in_mode == MODE_GROUP) && rej_now;
                    if (in_mode != MODE_TICK) begin
                        r_state <= S_OUT;
                    end else if (r_run == LAST) begin
                        r_state <= S_AGE;
                    end else begin
                        r_j     <= r_run + 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (cur.inr && cur.status == ST_RUN) begin
                        r_nxt   <= r_j;
                        r_state <= S_INC;
                    end else if (r_j == LAST) begin
                        r_state <= S_AGE;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_AGE: begin
                    r_round <= r_round + 32'd1;
                    r_low   <= '1;
                    r_j     <= '0;
                    r_state <= S_MIN;
                end
                S_MIN: begin
                    if (cur.status == ST_RUN && cur.dprio < r_low) r_low <= cur.dprio;
                    if (r_j == LAST) r_state <= S_SUB;
                    else r_j <= r_j + 1'b1;
                end
                S_SUB: begin
                    r_j     <= '0;
                    r_found <= 1'b0;
                    r_state <= S_CHARGE;
                end
                S_CHARGE: begin
                    if (cur.inr && !r_found) begin
                        r_found <= 1'b1;
                        r_nxt   <= r_j;
                    end
                    if (r_j == LAST) begin
                        if (!r_found && !cur.inr) r_nxt <= idle_eff;
                        r_state <= S_INC;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_INC: begin
                    r_run   <= r_nxt;
                    r_state <= S_DPSET;
                end
                S_DPSET: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {2'b00, r_round, r_rej,
                                     (r_run == idle_eff), run32[3:0]};
                        r_rej    <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign o_cfg_ready   = 1'b1;

endmodule
